// ===== rtl/core/ctm_pkg.sv =====
// ctm_pkg: shared types, constants and register codes for the cube tap and
// motion detector. No dependencies; imported by ctm_eval and the top level.
package ctm_pkg;

  localparam int OBJECT_COUNT = 32;
  localparam int IDX_W        = $clog2(OBJECT_COUNT);

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_MOVING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MOVING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_SQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STILL_TOL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_LIMIT    = 3'd4;

  localparam logic [4:0]  START_MOVING_RST = 5'd5;
  localparam logic [4:0]  STOP_MOVING_RST  = 5'd20;
  localparam logic [15:0] GRAVITY_SQ_RST   = 16'd4096;
  localparam logic [15:0] STILL_TOL_RST    = 16'd500;
  localparam logic [7:0]  TAP_LIMIT_RST    = 8'd16;

  // up axis codes
  localparam logic [2:0] UP_UNKNOWN = 3'd0;
  localparam logic [2:0] UP_X_POS   = 3'd1;
  localparam logic [2:0] UP_X_NEG   = 3'd2;
  localparam logic [2:0] UP_Y_POS   = 3'd3;
  localparam logic [2:0] UP_Y_NEG   = 3'd4;
  localparam logic [2:0] UP_Z_POS   = 3'd5;
  localparam logic [2:0] UP_Z_NEG   = 3'd6;

  typedef struct packed {
    logic [4:0]  start_moving;
    logic [4:0]  stop_moving;
    logic [15:0] gravity_sq;
    logic [15:0] still_tol;
    logic [7:0]  tap_limit;
  } ctm_cfg_t;

  // per-object state
  typedef struct packed {
    logic [7:0] last_shock;
    logic [4:0] motion_ctr;
    logic       moving;
    logic [2:0] prev_up;
  } ctm_entry_t;

  typedef struct packed {
    logic [7:0] report_id;
    logic       tap_event;
    logic [7:0] tap_total;
    logic       moved_event;
    logic       stopped_event;
    logic [2:0] up_axis;
  } ctm_result_t;

endpackage

// ===== rtl/core/ctm_eval.sv =====
// ctm_eval: evaluates one report against its object's state entry, giving the
// result and the updated entry. Combinational; depends on ctm_pkg.
module ctm_eval import ctm_pkg::*; (
  input  ctm_cfg_t    cfg,
  input  logic        in_range,
  input  logic [7:0]  object_id,
  input  logic [7:0]  shock_count,
  input  logic signed [7:0] accel_x,
  input  logic signed [7:0] accel_y,
  input  logic signed [7:0] accel_z,
  input  ctm_entry_t  ent,
  output ctm_entry_t  ent_nxt,
  output ctm_result_t res
);

  logic [7:0]  diff;
  logic        tap;
  logic [7:0]  mag_x, mag_y, mag_z, best;
  logic [2:0]  up;
  logic        changed;
  logic [15:0] sq_x, sq_y, sq_z;
  logic [15:0] sq;
  logic signed [17:0] sq_s, lo_s, hi_s;
  logic        moving_now;
  logic [4:0]  ctr;
  logic        moved, stopped;

  // -128 becomes 128, which still fits unsigned 8 bits
  assign mag_x = accel_x[7] ? 8'(-accel_x) : accel_x;
  assign mag_y = accel_y[7] ? 8'(-accel_y) : accel_y;
  assign mag_z = accel_z[7] ? 8'(-accel_z) : accel_z;

  assign diff = shock_count - ent.last_shock;
  assign tap  = (diff != 8'd0) && (diff < cfg.tap_limit);

  always_comb begin
    up   = UP_UNKNOWN;
    best = 8'd0;
    if (mag_x > best) begin
      up   = (accel_x > 8'sd0) ? UP_X_POS : UP_X_NEG;
      best = mag_x;
    end
    if (mag_y > best) begin
      up   = (accel_y > 8'sd0) ? UP_Y_POS : UP_Y_NEG;
      best = mag_y;
    end
    if (mag_z > best) begin
      up   = (accel_z > 8'sd0) ? UP_Z_POS : UP_Z_NEG;
      best = mag_z;
    end
  end

  assign changed = (ent.prev_up != UP_UNKNOWN) && (ent.prev_up != up);

  // squares of magnitudes; sum at most 3 * 128^2, fits 16 bits
  assign sq_x = mag_x * mag_x;
  assign sq_y = mag_y * mag_y;
  assign sq_z = mag_z * mag_z;
  assign sq   = sq_x + sq_y + sq_z;

  // window bounds kept signed and unwrapped
  assign sq_s = $signed({2'b00, sq});
  assign lo_s = $signed({2'b00, cfg.gravity_sq}) - $signed({2'b00, cfg.still_tol});
  assign hi_s = $signed({2'b00, cfg.gravity_sq}) + $signed({2'b00, cfg.still_tol});
  assign moving_now = !((sq_s >= lo_s) && (sq_s <= hi_s));

  always_comb begin
    ctr     = ent.motion_ctr;
    moved   = 1'b0;
    stopped = 1'b0;
    ent_nxt = ent;
    if (moving_now) begin
      if (ctr < cfg.stop_moving) ctr = ctr + 5'd1;
    end else if (ctr != 5'd0) begin
      ctr = ctr - 5'd1;
    end
    if (changed || ((ctr >= cfg.start_moving) && !ent.moving)) begin
      moved          = 1'b1;
      ent_nxt.moving = 1'b1;
      ctr            = cfg.stop_moving;
    end else if ((ctr == 5'd0) && ent.moving) begin
      stopped        = 1'b1;
      ent_nxt.moving = 1'b0;
    end
    ent_nxt.motion_ctr = ctr;
    ent_nxt.last_shock = shock_count;
    ent_nxt.prev_up    = up;
  end

  always_comb begin
    res.report_id     = object_id;
    res.tap_event     = 1'b0;
    res.tap_total     = 8'd0;
    res.moved_event   = 1'b0;
    res.stopped_event = 1'b0;
    res.up_axis       = UP_UNKNOWN;
    if (in_range) begin
      res.tap_event     = tap;
      res.tap_total     = tap ? diff : 8'd0;
      res.moved_event   = moved;
      res.stopped_event = stopped;
      res.up_axis       = up;
    end
  end

endmodule

// ===== rtl/core/cube_tap_motion_detector.sv =====
// cube_tap_motion_detector: per-object tap and motion event detector, top
// level. Holds configuration, input and result registers and the state table.
// Depends on ctm_pkg and ctm_eval.
// The input register is loaded at the accepting edge, and the result register is
// loaded from it as the item moves on, which a result held by out_ready delays.
// Throughput: one item per cycle; a result held by out_ready stalls both registers.
// The state entry is read for the held item and rewritten as the item moves on.
// Reset (synchronous, rst_n low) clears every state entry and loads defaults.
module cube_tap_motion_detector import ctm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_object_id,
  input  logic [7:0]           in_shock_count,
  input  logic signed [7:0]    in_accel_x,
  input  logic signed [7:0]    in_accel_y,
  input  logic signed [7:0]    in_accel_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_report_id,
  output logic                 out_tap_event,
  output logic [7:0]           out_tap_total,
  output logic                 out_moved_event,
  output logic                 out_stopped_event,
  output logic [2:0]           out_up_axis
);

  ctm_cfg_t          cfg_r;
  ctm_entry_t        st_r [OBJECT_COUNT];

  logic              v1_r;
  logic [7:0]        id_r, shock_r;
  logic signed [7:0] ax_r, ay_r, az_r;

  logic              out_valid_r;
  ctm_result_t       res_r;

  logic              s1_move;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  ctm_entry_t        ent, ent_nxt;
  ctm_result_t       res_nxt;

  assign s1_move  = v1_r && (!out_valid_r || out_ready);
  assign in_ready = !v1_r || s1_move;
  assign in_range = ({1'b0, id_r} < 9'(OBJECT_COUNT));
  assign idx      = id_r[IDX_W-1:0];
  assign ent      = st_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_moving <= START_MOVING_RST;
      cfg_r.stop_moving  <= STOP_MOVING_RST;
      cfg_r.gravity_sq   <= GRAVITY_SQ_RST;
      cfg_r.still_tol    <= STILL_TOL_RST;
      cfg_r.tap_limit    <= TAP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MOVING: cfg_r.start_moving <= cfg_wdata[4:0];
        REG_STOP_MOVING:  cfg_r.stop_moving  <= cfg_wdata[4:0];
        REG_GRAVITY_SQ:   cfg_r.gravity_sq   <= cfg_wdata;
        REG_STILL_TOL:    cfg_r.still_tol    <= cfg_wdata;
        REG_TAP_LIMIT:    cfg_r.tap_limit    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id_r    <= in_object_id;
      shock_r <= in_shock_count;
      ax_r    <= in_accel_x;
      ay_r    <= in_accel_y;
      az_r    <= in_accel_z;
    end
  end

  ctm_eval u_eval (
    .cfg         (cfg_r),
    .in_range    (in_range),
    .object_id   (id_r),
    .shock_count (shock_r),
    .accel_x     (ax_r),
    .accel_y     (ay_r),
    .accel_z     (az_r),
    .ent         (ent),
    .ent_nxt     (ent_nxt),
    .res         (res_nxt)
  );

  // state table: written as the item moves into the result register, so the
  // next item in the input register already sees the update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OBJECT_COUNT; i++) begin
        st_r[i] <= '0;
      end
    end else if (s1_move && in_range) begin
      st_r[idx] <= ent_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_report_id     = res_r.report_id;
  assign out_tap_event     = res_r.tap_event;
  assign out_tap_total     = res_r.tap_total;
  assign out_moved_event   = res_r.moved_event;
  assign out_stopped_event = res_r.stopped_event;
  assign out_up_axis       = res_r.up_axis;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v1_r)
    else $error("pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted item lost from input register");

  a_moved_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.moved_event && res_r.stopped_event))
    else $error("moved and stopped set together");

  a_tap_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.tap_event |-> res_r.tap_total == 8'd0)
    else $error("tap total without tap event");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && !in_range |=> !res_r.tap_event && !res_r.moved_event
      && !res_r.stopped_event && res_r.up_axis == UP_UNKNOWN)
    else $error("event for an id out of range");

endmodule
